FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define IER_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define IER_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ier_pkg.sv
package ier_pkg;

    localparam int TYPE_W     = 5;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 4;
    localparam int KEY_W      = 11;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int STEP_W     = 3;

    // Event types
    localparam logic [TYPE_W-1:0] T_SYN = 5'd0;
    localparam logic [TYPE_W-1:0] T_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] T_REL = 5'd2;

    // Key codes
    localparam logic [CODE_W-1:0] K_NONE = 10'd0;
    localparam logic [CODE_W-1:0] K_CTRL = 10'd29;
    localparam logic [CODE_W-1:0] K_C    = 10'd46;
    localparam logic [CODE_W-1:0] K_V    = 10'd47;

    // Key values
    localparam logic signed [VALUE_W-1:0] V_UP     = 32'sd0;
    localparam logic signed [VALUE_W-1:0] V_DOWN   = 32'sd1;
    localparam logic signed [VALUE_W-1:0] V_REPEAT = 32'sd2;

    // Special targets
    localparam logic signed [KEY_W-1:0] TGT_NONE  = -11'sd1;
    localparam logic signed [KEY_W-1:0] TGT_COPY  = -11'sd2;
    localparam logic signed [KEY_W-1:0] TGT_PASTE = -11'sd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

    localparam logic [CODE_W-1:0] RST_TOGGLE = 10'd275;
    localparam logic [CODE_W-1:0] RST_HOLD   = 10'd276;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        E_PASS,
        E_PRESS,
        E_RELEASE,
        E_TAP,
        E_CHORD
    } t_emit_kind;

    typedef struct packed {
        logic [TYPE_W-1:0]         src_type;
        logic [CODE_W-1:0]         src_code;
        logic signed [VALUE_W-1:0] src_value;
        logic signed [KEY_W-1:0]   target;
        logic                      layer;
    } t_entry;

    typedef struct packed {
        t_emit_kind                kind;
        logic [CODE_W-1:0]         key;
        logic [TYPE_W-1:0]         ev_type;
        logic [CODE_W-1:0]         ev_code;
        logic signed [VALUE_W-1:0] ev_value;
    } t_emit_req;

    typedef struct packed {
        logic [TYPE_W-1:0]         out_type;
        logic [CODE_W-1:0]         out_code;
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
    } t_res;

    // One emitted event; a pass gives its event, unnamed steps are syncs.
    function automatic t_res emit_item(t_emit_req req, logic [STEP_W-1:0] step);
        t_res r;
        r.out_type  = T_SYN;
        r.out_code  = K_NONE;
        r.out_value = V_UP;
        r.out_last  = 1'b0;
        case (req.kind)
            E_PASS: begin
                r.out_type  = req.ev_type;
                r.out_code  = req.ev_code;
                r.out_value = req.ev_value;
                r.out_last  = 1'b1;
            end
            E_PRESS, E_RELEASE: begin
                case (step)
                    3'd0: begin
                        r.out_type  = T_KEY;
                        r.out_code  = req.key;
                        r.out_value = (req.kind == E_PRESS) ? V_DOWN : V_UP;
                    end
                    default: r.out_last = 1'b1;
                endcase
            end
            E_TAP: begin
                case (step)
                    3'd0: begin
                        r.out_type  = T_KEY;
                        r.out_code  = req.key;
                        r.out_value = V_DOWN;
                    end
                    3'd2: begin
                        r.out_type  = T_KEY;
                        r.out_code  = req.key;
                        r.out_value = V_UP;
                    end
                    3'd3: r.out_last = 1'b1;
                    default: r.out_last = 1'b0;
                endcase
            end
            E_CHORD: begin
                case (step)
                    3'd0: begin
                        r.out_type  = T_KEY;
                        r.out_code  = K_CTRL;
                        r.out_value = V_DOWN;
                    end
                    3'd1: begin
                        r.out_type  = T_KEY;
                        r.out_code  = req.key;
                        r.out_value = V_DOWN;
                    end
                    3'd3: begin
                        r.out_type  = T_KEY;
                        r.out_code  = req.key;
                        r.out_value = V_UP;
                    end
                    3'd4: begin
                        r.out_type  = T_KEY;
                        r.out_code  = K_CTRL;
                        r.out_value = V_UP;
                    end
                    3'd5: r.out_last = 1'b1;
                    default: r.out_last = 1'b0;
                endcase
            end
            default: r.out_last = 1'b1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ier_ev_if.sv
interface ier_ev_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [ier_pkg::TYPE_W-1:0]        ev_type;
    logic [ier_pkg::CODE_W-1:0]        ev_code;
    logic signed [ier_pkg::VALUE_W-1:0] ev_value;
    logic [ier_pkg::IDX_W-1:0]         map_index;
    logic                              map_layer;
    logic signed [ier_pkg::KEY_W-1:0]  map_to_key;

    modport source (
        output valid, action, ev_type, ev_code, ev_value, map_index, map_layer, map_to_key,
        input  ready
    );
    modport sink (
        input  valid, action, ev_type, ev_code, ev_value, map_index, map_layer, map_to_key,
        output ready
    );
endinterface

FILE: rtl/core/ier_res_if.sv
interface ier_res_if;
    logic                              valid;
    logic                              ready;
    logic [ier_pkg::TYPE_W-1:0]        out_type;
    logic [ier_pkg::CODE_W-1:0]        out_code;
    logic signed [ier_pkg::VALUE_W-1:0] out_value;
    logic                              out_last;

    modport source (
        output valid, out_type, out_code, out_value, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_type, out_code, out_value, out_last,
        output ready
    );
endinterface

FILE: rtl/core/input_event_remapper_core.sv
// Input event remapper.
// Channel i_ev carries requests: a mapping write (action 1) stores one table entry,
// an event (action 0) is remapped. Channel o_res carries the emitted events, with
// out_last marking the final one of each request. i_cfg_* writes mapping_count,
// toggle_code and hold_code; write them only while the block is idle.
// Flow: a mapping write, a toggle key and a hold key emit nothing. Any other event
// is checked against the table entries in order (at most min(mapping_count,
// MAX_MAPPINGS) of them, one table memory read each) until the first match, then
// its results leave one per cycle while the sink is ready (a chord has six).
// i_ev.ready is low from acceptance of any other event until its last result sits
// in the output register, or until the scan drops the event.
// Reset: the held-key store is swept to inactive, one entry a cycle, and i_ev.ready
// stays low until the sweep is done; configuration writes are taken.
// A stalled sink holds the output register and its payload steady; the emitter
// waits behind it, while the scanner does not stall.
module input_event_remapper_core #(
    parameter int MAX_MAPPINGS = 16,
    parameter int CODE_COUNT   = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ier_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ier_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ier_ev_if.sink                           i_ev,
    ier_res_if.source                        o_res
);
    import ier_pkg::*;

    localparam int TBL_AW  = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;
    localparam int SCAN_W  = $clog2(MAX_MAPPINGS + 1);
    localparam int CMP_W   = (SCAN_W > CNT_W) ? SCAN_W : CNT_W;
    localparam int WI_W    = (SCAN_W > IDX_W) ? SCAN_W : IDX_W;
    localparam int HELD_AW = $clog2(CODE_COUNT);
    localparam int CC_W    = $clog2(CODE_COUNT + 1);
    localparam int RNG_W   = (CC_W > CODE_W) ? CC_W : CODE_W;

    // Configuration and control state
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_map_count;
    logic [CODE_W-1:0]  r_toggle;
    logic [CODE_W-1:0]  r_hold;
    logic               r_layer;
    logic [SCAN_W-1:0]  r_idx;
    logic [HELD_AW-1:0] r_clr;

    // Event under work
    logic [TYPE_W-1:0]         r_type;
    logic [CODE_W-1:0]         r_code;
    logic signed [VALUE_W-1:0] r_value;

    // Mapping table memory
    t_entry             r_tbl [MAX_MAPPINGS];
    t_entry             r_ent;
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_wa;
    logic [TBL_AW-1:0]  tbl_ra;

    // Held-target memory
    logic signed [KEY_W-1:0] r_held_mem [CODE_COUNT];
    logic signed [KEY_W-1:0] r_held;
    logic                    held_we;
    logic [HELD_AW-1:0]      held_wa;
    logic [HELD_AW-1:0]      held_ra;
    logic signed [KEY_W-1:0] held_wd;

    // Scan decision
    logic                    in_acc;
    logic                    is_toggle;
    logic                    is_hold;
    logic                    scan_done;
    logic                    key_hit;
    logic                    rel_hit;
    logic                    code_ok;
    logic                    wr_ok;
    logic                    clr_last;
    logic                    dec_start;
    logic                    dec_swallow;
    logic                    dec_held_we;
    logic signed [KEY_W-1:0] dec_held_wd;
    t_emit_req               dec_req;
    logic                    emit_start;
    logic                    emit_done;

    assign in_acc    = i_ev.valid && i_ev.ready;
    // Toggle wins when toggle and hold share a code
    assign is_toggle = (i_ev.ev_type == T_KEY) && (i_ev.ev_code == r_toggle);
    assign is_hold   = (i_ev.ev_type == T_KEY) && (i_ev.ev_code == r_hold) && !is_toggle;
    assign wr_ok     = WI_W'(i_ev.map_index) < WI_W'(MAX_MAPPINGS);
    assign clr_last  = r_clr == HELD_AW'(CODE_COUNT - 1);

    assign scan_done = (CMP_W'(r_idx) >= CMP_W'(r_map_count)) ||
                       (CMP_W'(r_idx) >= CMP_W'(MAX_MAPPINGS));
    assign key_hit   = (r_ent.layer == r_layer) && (r_type == T_KEY) &&
                       (r_ent.src_type == T_KEY) && (r_code == r_ent.src_code);
    assign rel_hit   = (r_ent.layer == r_layer) && (r_type == T_REL) &&
                       (r_ent.src_type == T_REL) && (r_code == r_ent.src_code) &&
                       (r_value == r_ent.src_value);
    assign code_ok   = RNG_W'(r_code) < RNG_W'(CODE_COUNT);

    // Decide the outcome of the entry in r_ent (first match ends the scan)
    always_comb begin
        dec_start        = 1'b0;
        dec_swallow      = 1'b0;
        dec_held_we      = 1'b0;
        dec_held_wd      = TGT_NONE;
        dec_req.kind     = E_PASS;
        dec_req.key      = K_NONE;
        dec_req.ev_type  = r_type;
        dec_req.ev_code  = r_code;
        dec_req.ev_value = r_value;
        if (scan_done) begin
            // no entry matched: pass the event through
            dec_start = 1'b1;
        end else if (key_hit) begin
            dec_swallow = 1'b1;
            if (!r_ent.target[KEY_W-1]) begin
                if (r_value == V_DOWN) begin
                    dec_held_we  = code_ok;
                    dec_held_wd  = r_ent.target;
                    dec_start    = 1'b1;
                    dec_swallow  = 1'b0;
                    dec_req.kind = E_PRESS;
                    dec_req.key  = r_ent.target[CODE_W-1:0];
                end else if (r_value == V_UP && code_ok && r_held != TGT_NONE) begin
                    dec_held_we  = 1'b1;
                    dec_start    = 1'b1;
                    dec_swallow  = 1'b0;
                    dec_req.kind = E_RELEASE;
                    dec_req.key  = r_held[CODE_W-1:0];
                end
            end else if (r_value == V_DOWN) begin
                if (r_ent.target == TGT_COPY) begin
                    dec_start    = 1'b1;
                    dec_swallow  = 1'b0;
                    dec_req.kind = E_CHORD;
                    dec_req.key  = K_C;
                end else if (r_ent.target == TGT_PASTE) begin
                    dec_start    = 1'b1;
                    dec_swallow  = 1'b0;
                    dec_req.kind = E_CHORD;
                    dec_req.key  = K_V;
                end
            end
        end else if (rel_hit) begin
            // relative match: tap the target's low code bits
            dec_start    = 1'b1;
            dec_req.kind = E_TAP;
            dec_req.key  = r_ent.target[CODE_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc && !i_ev.action && !is_toggle && !is_hold) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (dec_start) begin
                    n_state = S_EMIT;
                end else if (dec_swallow) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: if (emit_done) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs: handshake, memory ports, emitter start
    always_comb begin
        i_ev.ready = 1'b0;
        emit_start = 1'b0;
        tbl_we     = 1'b0;
        tbl_wa     = TBL_AW'(i_ev.map_index);
        tbl_ra     = TBL_AW'(r_idx + SCAN_W'(1));
        held_we    = 1'b0;
        held_wa    = HELD_AW'(r_code);
        held_wd    = dec_held_wd;
        held_ra    = HELD_AW'(r_code);
        case (r_state)
            S_CLEAR: begin
                held_we = 1'b1;
                held_wa = r_clr;
                held_wd = TGT_NONE;
            end
            S_IDLE: begin
                i_ev.ready = 1'b1;
                tbl_we     = in_acc && i_ev.action && wr_ok;
                // prefetch entry 0 and the held target of the arriving code
                tbl_ra     = '0;
                held_ra    = HELD_AW'(i_ev.ev_code);
            end
            S_SCAN: begin
                emit_start = dec_start;
                held_we    = dec_held_we;
            end
            default: emit_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_map_count <= '0;
            r_toggle    <= RST_TOGGLE;
            r_hold      <= RST_HOLD;
            r_layer     <= 1'b0;
            r_idx       <= '0;
            r_clr       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_COUNT: r_map_count <= i_cfg_data[CNT_W-1:0];
                    CFG_TOGGLE:    r_toggle    <= i_cfg_data;
                    CFG_HOLD:      r_hold      <= i_cfg_data;
                    default:       r_map_count <= r_map_count;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_IDLE && in_acc && !i_ev.action) begin
                r_idx <= '0;
                if (is_toggle && i_ev.ev_value == V_DOWN) begin
                    r_layer <= !r_layer;
                end else if (is_hold && i_ev.ev_value != V_REPEAT) begin
                    r_layer <= i_ev.ev_value != V_UP;
                end
            end else if (r_state == S_SCAN && !dec_start && !dec_swallow) begin
                // advance to the next entry
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Capture the event under work
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type  <= i_ev.ev_type;
            r_code  <= i_ev.ev_code;
            r_value <= i_ev.ev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_wa] <= '{src_type:  i_ev.ev_type,
                               src_code:  i_ev.ev_code,
                               src_value: i_ev.ev_value,
                               target:    i_ev.map_to_key,
                               layer:     i_ev.map_layer};
        end
        r_ent <= r_tbl[tbl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held_mem[held_wa] <= held_wd;
        end
        r_held <= r_held_mem[held_ra];
    end

    ier_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (emit_start),
        .i_req   (dec_req),
        .o_done  (emit_done),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/core/ier_emit.sv
module ier_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ier_pkg::t_emit_req i_req,
    output logic               o_done,
    ier_res_if.source          o_res
);
    import ier_pkg::*;

    logic              r_busy;
    logic              r_ovalid;
    logic [STEP_W-1:0] r_step;
    t_emit_req         r_req;
    t_res              r_res;
    t_res              item;
    logic              out_free;
    logic              load;

    assign out_free = !r_ovalid || o_res.ready;
    assign load     = r_busy && out_free;
    assign item     = emit_item(r_req, r_step);
    assign o_done   = load && item.out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (o_done) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload: sequence request, step and output register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req  <= i_req;
            r_step <= '0;
        end else if (load) begin
            r_step <= r_step + 1'b1;
        end
        if (load) begin
            r_res <= item;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.out_type  = r_res.out_type;
    assign o_res.out_code  = r_res.out_code;
    assign o_res.out_value = r_res.out_value;
    assign o_res.out_last  = r_res.out_last;

endmodule

FILE: rtl/core/ier_checker.sv
`include "assert_macros.svh"

module ier_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_in_action,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ier_pkg::TYPE_W-1:0]      i_out_type,
    input logic [ier_pkg::CODE_W-1:0]      i_out_code,
    input logic [ier_pkg::VALUE_W-1:0]     i_out_value,
    input logic                            i_out_last
);
    import ier_pkg::*;

    logic [TYPE_W+CODE_W+VALUE_W:0] out_bits;

    assign out_bits = {i_out_type, i_out_code, i_out_value, i_out_last};

    `IER_ASSERT(a_out_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `IER_ASSERT(a_out_data_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(out_bits), "result changed while stalled")
    `IER_ASSERT(a_write_no_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_action |=> i_in_ready, "mapping write blocked the input")
    `IER_ASSERT_NEVER(a_ready_mid_seq, i_clk, i_rst_n, i_out_valid && !i_out_last && i_in_ready, "input ready before last result")

endmodule

bind input_event_remapper_core ier_checker u_ier_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_ev.valid),
    .i_in_ready  (i_ev.ready),
    .i_in_action (i_ev.action),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_type  (o_res.out_type),
    .i_out_code  (o_res.out_code),
    .i_out_value (o_res.out_value),
    .i_out_last  (o_res.out_last)
);
